// ===== hw/rtl/mbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mbd_pkg
// shared types and constants of the mip map box downsampler
// ----------------------------------------------------------------------------
package mbd_pkg;

	localparam int CFG_W = 11;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} pixel_t;

	typedef struct packed {
		logic [3:0] mip_level;
		logic [8:0] pixel_x;
		logic [8:0] pixel_y;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       level_end;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic             clear;
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
	} cfg_t;

endpackage

// ===== hw/rtl/mbd_fifo.sv =====
// ----------------------------------------------------------------------------
// mbd_fifo
// small register queue that decouples the two sides of a transfer
// ----------------------------------------------------------------------------
module mbd_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	T              store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== hw/rtl/mbd_level_engine.sv =====
// ----------------------------------------------------------------------------
// mbd_level_engine
// walks one pixel down the mip cascade, one level per step
// ----------------------------------------------------------------------------
module mbd_level_engine #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int LEVELS = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mbd_pkg::cfg_t   cfg,
	input  logic            src_empty,
	input  mbd_pkg::pixel_t src_data,
	output logic            src_pop,
	input  logic            dst_full,
	output logic            dst_push,
	output mbd_pkg::result_t dst_data
);
	import mbd_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int KW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int HALF = MAX_WIDTH / 2;
	localparam int MD   = LEVELS * HALF;
	localparam int AW   = (MD > 1) ? $clog2(MD) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_AVG, ST_FLUSH} state_t;

	state_t         state_q;
	logic [KW-1:0]  lvl_q;
	logic [7:0]     px_q [4];
	logic [31:0]    held_q [LEVELS];
	logic [CW-1:0]  col_q [LEVELS];
	logic [RW-1:0]  row_q [LEVELS];
	logic [35:0]    line_mem [MD];
	logic [35:0]    line_s2;
	result_t        pend_q;
	logic           pend_v_q;
	logic [8:0]     ox_q;
	logic [8:0]     oy_q;
	logic           oend_q;

	logic [WW-1:0]  w_c;
	logic [HW-1:0]  h_c;
	logic [WW-1:0]  lw;
	logic [HW-1:0]  lh;
	logic [WW-1:0]  wn;
	logic [HW-1:0]  hn;
	logic [CW-1:0]  x;
	logic [RW-1:0]  y;
	logic [CW-1:0]  ox;
	logic [RW-1:0]  oy;
	logic           x_wrap;
	logic           y_wrap;
	logic           drop;
	logic [AW-1:0]  addr;
	logic [35:0]    pair;
	logic           step;
	logic [7:0]     avg [4];
	logic [9:0]     sum [4];
	logic           oend;
	result_t        res;

	always_comb begin
		if (cfg.width == '0) begin
			w_c = WW'(1);
		end else if (int'(cfg.width) > MAX_WIDTH) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(cfg.width);
		end
		if (cfg.height == '0) begin
			h_c = HW'(1);
		end else if (int'(cfg.height) > MAX_HEIGHT) begin
			h_c = HW'(MAX_HEIGHT);
		end else begin
			h_c = HW'(cfg.height);
		end
	end

	assign x      = col_q[lvl_q];
	assign y      = row_q[lvl_q];
	assign lw     = w_c >> lvl_q;
	assign lh     = h_c >> lvl_q;
	assign wn     = lw >> 1;
	assign hn     = lh >> 1;
	assign ox     = x >> 1;
	assign oy     = y >> 1;
	assign x_wrap = ((WW + 1)'(x) + 1'b1) >= (WW + 1)'(lw);
	assign y_wrap = ((HW + 1)'(y) + 1'b1) >= (HW + 1)'(lh);
	assign drop   = ((WW + 1)'(x) >= (WW + 1)'({wn, 1'b0}))
	             || ((HW + 1)'(y) >= (HW + 1)'({hn, 1'b0}));
	assign oend   = (((WW + 1)'(ox) + 1'b1) == (WW + 1)'(wn))
	             && (((HW + 1)'(oy) + 1'b1) == (HW + 1)'(hn));
	assign addr   = AW'(int'(lvl_q) * HALF + int'(ox));
	assign step   = (state_q == ST_RUN) && !dst_full;
	assign src_pop = (state_q == ST_IDLE) && !src_empty;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			pair[9*c +: 9] = 9'(held_q[lvl_q][8*c +: 8]) + 9'(px_q[c]);
			sum[c] = 10'(line_s2[9*c +: 9]) + 10'(held_q[lvl_q][8*c +: 8]) + 10'(px_q[c]);
			avg[c] = sum[c][9:2];
		end
	end

	always_comb begin
		res.mip_level = 4'(int'(lvl_q) + 1);
		res.pixel_x   = ox_q;
		res.pixel_y   = oy_q;
		res.red_out   = avg[0];
		res.green_out = avg[1];
		res.blue_out  = avg[2];
		res.alpha_out = avg[3];
		res.level_end = oend_q;
		res.run_last  = 1'b0;
	end

	always_comb begin
		dst_push = 1'b0;
		dst_data = pend_q;
		if (state_q == ST_AVG && pend_v_q) begin
			dst_push = 1'b1;
		end else if (state_q == ST_FLUSH && pend_v_q && !dst_full) begin
			dst_push = 1'b1;
			dst_data.run_last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && !drop && x[0] && !y[0]) begin
			line_mem[addr] <= pair;
		end
		if (step) begin
			line_s2 <= line_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (step && !drop && !x[0]) begin
			held_q[lvl_q] <= {px_q[3], px_q[2], px_q[1], px_q[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			lvl_q    <= '0;
			pend_v_q <= 1'b0;
			for (int k = 0; k < LEVELS; k++) begin
				col_q[k] <= '0;
				row_q[k] <= '0;
			end
		end else begin
			if (cfg.clear) begin
				for (int k = 0; k < LEVELS; k++) begin
					col_q[k] <= '0;
					row_q[k] <= '0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (!src_empty) begin
						px_q[0]  <= src_data.red_in;
						px_q[1]  <= src_data.green_in;
						px_q[2]  <= src_data.blue_in;
						px_q[3]  <= src_data.alpha_in;
						lvl_q    <= '0;
						pend_v_q <= 1'b0;
						state_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (step) begin
						if (x_wrap) begin
							col_q[lvl_q] <= '0;
							row_q[lvl_q] <= y_wrap ? '0 : y + 1'b1;
						end else begin
							col_q[lvl_q] <= x + 1'b1;
						end
						ox_q   <= 9'(ox);
						oy_q   <= 9'(oy);
						oend_q <= oend;
						if (drop || !x[0] || !y[0]) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_AVG;
						end
					end
				end
				ST_AVG: begin
					pend_q   <= res;
					pend_v_q <= 1'b1;
					px_q     <= avg;
					if (int'(lvl_q) + 1 == LEVELS) begin
						state_q <= ST_FLUSH;
					end else begin
						lvl_q   <= lvl_q + 1'b1;
						state_q <= ST_RUN;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (!dst_full) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		dst_push |-> !dst_full)
		else $error("result pushed into full queue");
	a_avg_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_AVG |-> $past(state_q) == ST_RUN)
		else $error("averaging step without a line read");
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> int'(lvl_q) < LEVELS)
		else $error("level index out of range");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		src_pop |=> state_q == ST_RUN && lvl_q == '0)
		else $error("new pixel did not start at level one");
`endif
endmodule

// ===== hw/rtl/mipmap_box_downsampler.sv =====
// a pixel is popped in ST_IDLE, then visits ST_RUN at each level and ends in ST_FLUSH
// a level that forms a 2x2 average (line store read) also visits ST_AVG after its ST_RUN
// the engine pops a new pixel only after ST_FLUSH of the previous one
// results wait in a 4-entry queue, inputs in a 2-entry queue
// reset: asynchronous, active low; sizes return to 1024 x 1024, counts to zero
// ----------------------------------------------------------------------------
// mipmap_box_downsampler
// builds mip levels 1..LEVELS from a raster stream of rgba8 pixels
// ----------------------------------------------------------------------------
module mipmap_box_downsampler #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int LEVELS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  mbd_pkg::pixel_t              pixel,
	output logic                         full,
	output logic                         empty,
	input  logic                         pop,
	output mbd_pkg::result_t             result,
	input  logic                         wr_en,
	input  logic [mbd_pkg::IDX_W-1:0]    wr_index,
	input  logic [mbd_pkg::CFG_W-1:0]    wr_data
);
	import mbd_pkg::*;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	cfg_t             cfg;
	logic             src_empty;
	logic             src_pop;
	pixel_t           src_data;
	logic             dst_full;
	logic             dst_push;
	result_t          dst_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1024);
			height_q <= CFG_W'(1024);
		end else if (wr_en) begin
			case (wr_index)
				REG_SOURCE_WIDTH:  width_q  <= wr_data;
				REG_SOURCE_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg.clear  = wr_en && (wr_index == REG_SOURCE_WIDTH || wr_index == REG_SOURCE_HEIGHT);
	assign cfg.width  = width_q;
	assign cfg.height = height_q;

	mbd_fifo #(.T(pixel_t), .DEPTH(2)) u_in_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (pixel),
		.full  (full),
		.pop   (src_pop),
		.rdata (src_data),
		.empty (src_empty)
	);

	mbd_level_engine #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.LEVELS    (LEVELS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.src_empty(src_empty),
		.src_data (src_data),
		.src_pop  (src_pop),
		.dst_full (dst_full),
		.dst_push (dst_push),
		.dst_data (dst_data)
	);

	mbd_fifo #(.T(result_t), .DEPTH(4)) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (dst_push),
		.wdata (dst_data),
		.full  (dst_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);
endmodule
